// File: hw/rtl/aes_block_cipher_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/aes_pkg.sv
// Package with AES tables, types and helper functions.
package aes_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [127:0] blk_t;

	localparam logic [1:0] MODE_128 = 2'd0;
	localparam logic [1:0] MODE_192 = 2'd1;
	localparam logic [1:0] MODE_256 = 2'd2;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	localparam logic [7:0] POLY = 8'h1b;

	typedef struct packed {
		logic        start;
		logic [5:0]  words;
		logic [2:0]  nk;
	} ks_ctl_t;

	function automatic byte_t sbox(input byte_t a);
		byte_t t [256];
		t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic byte_t sbox_inv(input byte_t a);
		byte_t t [256];
		t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic byte_t xt(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
	endfunction

	function automatic word_t word_sbox(input word_t w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// File: hw/rtl/aes_round.sv
// Shared round unit: one full forward or inverse AES round per cycle.
module aes_round (
	input  aes_pkg::blk_t st,
	input  aes_pkg::blk_t rk,
	input  logic          inv,
	input  logic          last,
	output aes_pkg::blk_t nxt
);
	aes_pkg::byte_t s [16];
	aes_pkg::byte_t t [16];
	aes_pkg::byte_t u [16];
	aes_pkg::byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
	aes_pkg::byte_t b0, b1, b2, b3, e0, e1;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			s[k] = st[127 - 8*k -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					t[c*4 + r] = aes_pkg::sbox_inv(s[((c + 4 - r) % 4)*4 + r]);
				end else begin
					t[c*4 + r] = aes_pkg::sbox(s[((c + r) % 4)*4 + r]);
				end
			end
		end
		if (inv) begin
			for (int k = 0; k < 16; k++) begin
				t[k] = t[k] ^ rk[127 - 8*k -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
			b0 = a0; b1 = a1; b2 = a2; b3 = a3;
			e0 = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
			e1 = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
			if (inv) begin
				b0 = a0 ^ e0; b1 = a1 ^ e1; b2 = a2 ^ e0; b3 = a3 ^ e1;
			end
			x0 = aes_pkg::xt(b0); x1 = aes_pkg::xt(b1);
			x2 = aes_pkg::xt(b2); x3 = aes_pkg::xt(b3);
			y0 = x0 ^ x1 ^ b1 ^ b2 ^ b3;
			y1 = b0 ^ x1 ^ x2 ^ b2 ^ b3;
			y2 = b0 ^ b1 ^ x2 ^ x3 ^ b3;
			y3 = x0 ^ b0 ^ b1 ^ b2 ^ x3;
			if (last) begin
				u[c*4] = a0; u[c*4+1] = a1; u[c*4+2] = a2; u[c*4+3] = a3;
			end else begin
				u[c*4] = y0; u[c*4+1] = y1; u[c*4+2] = y2; u[c*4+3] = y3;
			end
		end
		for (int k = 0; k < 16; k++) begin
			nxt[127 - 8*k -: 8] = inv ? u[k] : (u[k] ^ rk[127 - 8*k -: 8]);
		end
	end
endmodule

// File: hw/rtl/aes_keysched.sv
// Key expansion sequencer: one schedule word per cycle into the word store.
module aes_keysched (
	input  logic           clk,
	input  logic           arst_n,
	input  aes_pkg::ks_ctl_t ctl,
	input  logic [255:0]   key,
	output logic           done,
	output logic           we,
	output logic [5:0]     waddr,
	output aes_pkg::word_t wdata
);
	logic           run_q;
	logic [5:0]     i_q;
	logic [2:0]     j_q;
	logic [3:0]     rc_q;
	aes_pkg::word_t w_q [8];
	aes_pkg::word_t t, nw, rot;
	logic [7:0]     rcon;
	logic [5:0]     nk_w;

	// A key length of eight words is carried as zero in the three-bit count.
	assign nk_w = (ctl.nk == 3'd0) ? 6'd8 : {3'd0, ctl.nk};

	always_comb begin
		case (rc_q)
			4'd0: rcon = 8'h01;
			4'd1: rcon = 8'h02;
			4'd2: rcon = 8'h04;
			4'd3: rcon = 8'h08;
			4'd4: rcon = 8'h10;
			4'd5: rcon = 8'h20;
			4'd6: rcon = 8'h40;
			4'd7: rcon = 8'h80;
			4'd8: rcon = 8'h1b;
			default: rcon = 8'h36;
		endcase
		t = w_q[ctl.nk - 3'd1];
		rot = {t[23:0], t[31:24]};
		if (i_q < nk_w) begin
			nw = key[255 - 32*i_q[2:0] -: 32];
		end else if (j_q == 3'd0) begin
			nw = w_q[0] ^ aes_pkg::word_sbox(rot) ^ {rcon, 24'h0};
		end else if (ctl.nk == 3'd0 && j_q == 3'd4) begin
			nw = w_q[0] ^ aes_pkg::word_sbox(t);
		end else begin
			nw = w_q[0] ^ t;
		end
	end

	assign we = run_q;
	assign waddr = i_q;
	assign wdata = nw;
	assign done = run_q && (i_q == ctl.words - 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			rc_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			i_q <= '0;
			j_q <= '0;
			rc_q <= '0;
		end else if (run_q) begin
			run_q <= !done;
			i_q <= i_q + 6'd1;
			if (j_q == ctl.nk - 3'd1) begin
				j_q <= '0;
				if (i_q >= nk_w) rc_q <= rc_q + 4'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			for (int k = 0; k < 7; k++) begin
				if (3'(k) < ctl.nk - 3'd1) w_q[k] <= w_q[k+1];
			end
			w_q[ctl.nk - 3'd1] <= nw;
		end
	end
endmodule

// File: hw/rtl/aes_block_cipher.sv
// Top level of the iterative AES encrypt and decrypt core.
// Usage: write key registers over APB, then raise start with operation and
// the 128-bit block while busy is low. The item is taken at that edge.
// Encryption or decryption runs one full round per cycle through a single
// shared round unit. An item passes from acceptance through ST_RD, ST_RUN
// and ST_OUT to the done strobe, with ST_KEY first to expand the 4*(Nr+1)
// round-key words on the first item after reset or any register write.
// The round-key words come from a 60-word store, read four words per round.
// The result is on result_high and result_low for one cycle with done high.
// The receiver cannot stall; it must take the item in that cycle.
// busy is high from acceptance until the done cycle ends.
// Reset clears the key registers, the mode and the schedule flag; the
// round-key store holds no contents until the first expansion.
// Register writes are expected only while busy is low.
module aes_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_KEY  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t         state_q;
	logic [63:0]    k0_q, k1_q, k2_q, k3_q;
	logic [1:0]     mode_q;
	logic           ready_q, op_q, ks_go_q;
	aes_pkg::blk_t  st_q, nxt;
	logic [3:0]     rnd_q, nr;
	aes_pkg::word_t mem [4][15];
	aes_pkg::blk_t  rk_q;
	logic [3:0]     rd_rnd;
	logic           wr_en, ks_done, ks_we;
	logic [5:0]     ks_addr;
	aes_pkg::word_t ks_data;
	aes_pkg::ks_ctl_t ctl;
	logic [2:0]     nk;
	logic [2:0]     widx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign widx = paddr[5:3];
	assign nk = (mode_q == aes_pkg::MODE_128) ? 3'd4 :
		(mode_q == aes_pkg::MODE_192) ? 3'd6 : 3'd0;
	assign nr = (mode_q == aes_pkg::MODE_128) ? 4'd10 :
		(mode_q == aes_pkg::MODE_192) ? 4'd12 : 4'd14;
	assign ctl.start = ks_go_q;
	assign ctl.nk = nk;
	assign ctl.words = {nr, 2'b00} + 6'd4;

	always_comb begin
		case (widx)
			aes_pkg::REG_KEY0: prdata = k0_q;
			aes_pkg::REG_KEY1: prdata = k1_q;
			aes_pkg::REG_KEY2: prdata = k2_q;
			aes_pkg::REG_KEY3: prdata = k3_q;
			aes_pkg::REG_MODE: prdata = {62'd0, mode_q};
			default: prdata = '0;
		endcase
	end

	aes_keysched u_ks (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .key({k0_q, k1_q, k2_q, k3_q}),
		.done(ks_done), .we(ks_we), .waddr(ks_addr), .wdata(ks_data)
	);

	aes_round u_rnd (
		.st(st_q), .rk(rk_q), .inv(op_q), .last(rnd_q == 4'd1), .nxt(nxt)
	);

	always_ff @(posedge clk) begin
		if (ks_we) mem[ks_addr[1:0]][ks_addr[5:2]] <= ks_data;
		rk_q <= {mem[0][rd_rnd], mem[1][rd_rnd], mem[2][rd_rnd], mem[3][rd_rnd]};
	end

	// Round index read next: counts rounds left, mapped by direction.
	always_comb begin
		if (state_q == ST_RD) begin
			rd_rnd = op_q ? nr : 4'd0;
		end else if (op_q) begin
			rd_rnd = rnd_q - 4'd2;
		end else begin
			rd_rnd = nr - rnd_q + 4'd2;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);
	assign result_high = st_q[127:64];
	assign result_low = st_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k0_q <= '0; k1_q <= '0; k2_q <= '0; k3_q <= '0;
			mode_q <= aes_pkg::MODE_128;
			ready_q <= 1'b0;
			ks_go_q <= 1'b0;
			op_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			ks_go_q <= (state_q == ST_IDLE) && start && !ready_q;
			if (wr_en) begin
				if (widx <= aes_pkg::REG_MODE) ready_q <= 1'b0;
				case (widx)
					aes_pkg::REG_KEY0: k0_q <= pwdata;
					aes_pkg::REG_KEY1: k1_q <= pwdata;
					aes_pkg::REG_KEY2: k2_q <= pwdata;
					aes_pkg::REG_KEY3: k3_q <= pwdata;
					aes_pkg::REG_MODE: mode_q <= pwdata[1] ? aes_pkg::MODE_256 : pwdata[1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= operation;
						if (ready_q) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_KEY;
						end
					end
				end
				ST_KEY: begin
					if (ks_done) begin
						ready_q <= 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_RUN;
					rnd_q <= nr + 4'd1;
				end
				ST_RUN: begin
					rnd_q <= rnd_q - 4'd1;
					if (rnd_q == 4'd1) state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			st_q <= {block_high, block_low};
		end else if (state_q == ST_RUN) begin
			if (rnd_q == nr + 4'd1) st_q <= st_q ^ rk_q;
			else st_q <= nxt;
		end
	end
endmodule

// File: hw/rtl/aes_block_cipher_chk.sv
// Port-level checker for the AES core, bound to the top level.
`include "aes_block_cipher_macros.svh"
module aes_block_cipher_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);
	`AES_ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`AES_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`AES_ASSERT_NXT(a_done_free, clk, arst_n, done, !busy && !done)
	`AES_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind aes_block_cipher aes_block_cipher_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .pready(pready)
);
